>>> src/shadow_brightness_ratio_smoother_core_defines.svh
// Assertion macros for the shadow brightness ratio smoother.
// Used by modules that have clk and rst_n in scope; no other dependencies.
`ifndef SHADOW_BRIGHTNESS_RATIO_SMOOTHER_CORE_DEFINES_SVH
`define SHADOW_BRIGHTNESS_RATIO_SMOOTHER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SBRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SBRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/sbrs_pkg.sv
// Shared types and constants for the shadow brightness ratio smoother.
// No dependencies; used by every module of the block.
package sbrs_pkg;

  localparam int LINE_MAX   = 2048;
  localparam int FRAME_MAX  = 4096;
  localparam int COL_W      = $clog2(LINE_MAX);
  localparam int ROW_W      = $clog2(FRAME_MAX);
  localparam int EFFW_W     = $clog2(LINE_MAX + 1);
  localparam int EFFH_W     = $clog2(FRAME_MAX + 1);
  localparam int LW_W       = 12;
  localparam int FH_W       = 13;
  localparam int MIN_SIZE   = 3;
  localparam int PIX_W      = 8;
  localparam int RATIO_W    = 16;
  localparam int LANES      = 3;
  localparam int SUM_W      = 19;
  localparam int RECIP_W    = 19;
  localparam int MEAN_SHIFT = 21;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYC    = RATIO_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYC);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [RATIO_W-1:0] INVALID_RATIO = {RATIO_W{1'b1}};
  // ceil(2^21 / 5): exact quotient by five for sums below 2^19
  localparam logic [RECIP_W-1:0] MEAN_RECIP = 19'd419431;
  localparam logic [PIX_W-1:0]   MASK_ON    = 8'hFF;
  localparam logic [PIX_W-1:0]   MASK_OFF   = 8'h00;

  localparam logic [LW_W-1:0] LINE_WIDTH_RST   = 12'd1216;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd684;

  // register index taken from paddr[2]
  localparam logic CFG_IDX_LINE_WIDTH   = 1'b0;
  localparam logic CFG_IDX_FRAME_HEIGHT = 1'b1;

  typedef struct packed {
    logic             op;
    logic [PIX_W-1:0] mask_blue;
    logic [PIX_W-1:0] mask_green;
    logic [PIX_W-1:0] mask_red;
    logic [PIX_W-1:0] scene_blue;
    logic [PIX_W-1:0] scene_green;
    logic [PIX_W-1:0] scene_red;
    logic [PIX_W-1:0] backdrop_blue;
    logic [PIX_W-1:0] backdrop_green;
    logic [PIX_W-1:0] backdrop_red;
  } sbrs_in_t;

  typedef struct packed {
    logic               is_shadow;
    logic               is_border;
    logic [RATIO_W-1:0] ratio_blue;
    logic [RATIO_W-1:0] ratio_green;
    logic [RATIO_W-1:0] ratio_red;
    logic               frame_end;
  } sbrs_out_t;

  // classified item between front and back; lane 0 blue, 1 green, 2 red
  typedef struct packed {
    logic                        drain;
    logic                        shadow;
    logic [LANES-1:0][PIX_W-1:0] scene;
    logic [LANES-1:0][PIX_W-1:0] backdrop;
  } sbrs_cmd_t;

  // line store entry
  typedef struct packed {
    logic                          shadow;
    logic [LANES-1:0][RATIO_W-1:0] ratio;
  } sbrs_cell_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_FIN
  } sbrs_state_t;

endpackage

>>> src/sbrs_front.sv
// Front end: takes input transfers, classifies them and queues them.
// Depends on sbrs_pkg.
module sbrs_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbrs_pkg::sbrs_in_t  in_data,
  input  logic                pop_i,
  output logic                q_valid_o,
  output sbrs_pkg::sbrs_cmd_t q_cmd_o
);

  sbrs_pkg::sbrs_cmd_t                q_r [sbrs_pkg::QDEPTH];
  logic [sbrs_pkg::QPTR_W-1:0]        wr_ptr_r;
  logic [sbrs_pkg::QPTR_W-1:0]        rd_ptr_r;
  logic [sbrs_pkg::QCNT_W-1:0]        cnt_r;
  sbrs_pkg::sbrs_cmd_t                cls;
  logic                               push;
  logic                               pop;

  // classify: pure green mask marks shadow
  always_comb begin
    cls.drain       = in_data.op;
    cls.shadow      = (in_data.mask_blue == sbrs_pkg::MASK_OFF) &&
                      (in_data.mask_green == sbrs_pkg::MASK_ON) &&
                      (in_data.mask_red == sbrs_pkg::MASK_OFF);
    cls.scene[0]    = in_data.scene_blue;
    cls.scene[1]    = in_data.scene_green;
    cls.scene[2]    = in_data.scene_red;
    cls.backdrop[0] = in_data.backdrop_blue;
    cls.backdrop[1] = in_data.backdrop_green;
    cls.backdrop[2] = in_data.backdrop_red;
  end

  assign in_ready  = cnt_r != sbrs_pkg::QCNT_W'(sbrs_pkg::QDEPTH);
  assign push      = in_valid && in_ready;
  assign q_valid_o = cnt_r != '0;
  assign pop       = pop_i && q_valid_o;
  assign q_cmd_o   = q_r[rd_ptr_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> src/sbrs_div.sv
// Three-lane radix-16 restoring divider for (scene << 8) / backdrop.
// Depends on sbrs_pkg; a zero divisor yields a zero quotient.
module sbrs_div (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            start_i,
  input  logic [sbrs_pkg::LANES-1:0][sbrs_pkg::PIX_W-1:0] num_i,
  input  logic [sbrs_pkg::LANES-1:0][sbrs_pkg::PIX_W-1:0] den_i,
  output logic                                            done_o,
  output logic [sbrs_pkg::LANES-1:0][sbrs_pkg::RATIO_W-1:0] quot_o
);

  logic [sbrs_pkg::LANES-1:0][sbrs_pkg::RATIO_W-1:0] num_r, num_nxt;
  logic [sbrs_pkg::LANES-1:0][sbrs_pkg::PIX_W-1:0]   rem_r, rem_nxt;
  logic [sbrs_pkg::LANES-1:0][sbrs_pkg::PIX_W-1:0]   den_r;
  logic [sbrs_pkg::DIV_CNT_W-1:0]                    cnt_r;
  logic                                              busy_r;

  // four quotient bits per cycle in each lane
  always_comb begin
    logic [sbrs_pkg::PIX_W:0] part;
    logic                     qb;
    num_nxt = num_r;
    rem_nxt = rem_r;
    for (int l = 0; l < sbrs_pkg::LANES; l++) begin
      for (int k = 0; k < sbrs_pkg::DIV_STEPS; k++) begin
        part = {rem_nxt[l], num_nxt[l][sbrs_pkg::RATIO_W-1]};
        if (part >= {1'b0, den_r[l]}) begin
          part = part - {1'b0, den_r[l]};
          qb   = 1'b1;
        end else begin
          qb   = 1'b0;
        end
        rem_nxt[l] = part[sbrs_pkg::PIX_W-1:0];
        num_nxt[l] = {num_nxt[l][sbrs_pkg::RATIO_W-2:0], qb};
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk) begin
    if (start_i) begin
      for (int l = 0; l < sbrs_pkg::LANES; l++) begin
        num_r[l] <= {num_i[l], {sbrs_pkg::PIX_W{1'b0}}};
      end
      rem_r <= '0;
      den_r <= den_i;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (done_o) busy_r <= 1'b0;
    end
  end

  assign done_o = busy_r && (cnt_r == sbrs_pkg::DIV_CNT_W'(sbrs_pkg::DIV_CYC - 1));

  always_comb begin
    for (int l = 0; l < sbrs_pkg::LANES; l++) begin
      quot_o[l] = (den_r[l] == '0) ? '0 : num_r[l];
    end
  end

endmodule

>>> src/sbrs_back.sv
// Back end: ratio division, line stores, five-point smoothing and result register.
// Depends on sbrs_pkg, sbrs_div and the assertion macro header.
`include "shadow_brightness_ratio_smoother_core_defines.svh"

module sbrs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sbrs_pkg::LW_W-1:0]   line_width_i,
  input  logic [sbrs_pkg::FH_W-1:0]   frame_height_i,
  input  logic                        q_valid_i,
  input  sbrs_pkg::sbrs_cmd_t         q_cmd_i,
  output logic                        pop_o,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sbrs_pkg::sbrs_out_t         out_data
);

  localparam int PROD_W = sbrs_pkg::SUM_W + sbrs_pkg::RECIP_W;

  // line stores: raw lines ping-pong on bank_r, smoothed line in place
  sbrs_pkg::sbrs_cell_t raw_mem    [2 * sbrs_pkg::LINE_MAX];
  sbrs_pkg::sbrs_cell_t smooth_mem [sbrs_pkg::LINE_MAX];

  sbrs_pkg::sbrs_state_t             state_r, state_nxt;
  logic [sbrs_pkg::COL_W-1:0]        col_r, col_use;
  logic [sbrs_pkg::ROW_W-1:0]        row_r;
  logic                              bank_r;
  logic                              draining_r;
  sbrs_pkg::sbrs_cell_t              left_r;
  logic                              cmd_drain_r;
  logic                              cmd_shadow_r;
  sbrs_pkg::sbrs_cell_t              rd_self_r, rd_right_r, rd_up_r;
  logic [sbrs_pkg::LANES-1:0][sbrs_pkg::SUM_W-1:0] sum_r;
  logic                              out_valid_r;
  sbrs_pkg::sbrs_out_t               out_data_r;

  logic [sbrs_pkg::EFFW_W-1:0]       w_eff;
  logic [sbrs_pkg::EFFH_W-1:0]       h_eff;
  logic                              last_col, last_row;
  logic                              pop, rd_en, div_start, div_done, fin_go;
  logic                              emit, can_load, interior;
  logic [sbrs_pkg::LANES-1:0][sbrs_pkg::RATIO_W-1:0] quot;
  sbrs_pkg::sbrs_cell_t              pix, res;
  logic [sbrs_pkg::LANES-1:0][PROD_W-1:0] prod;

  // clamp sizes to the supported range
  always_comb begin
    if (line_width_i < sbrs_pkg::LW_W'(sbrs_pkg::MIN_SIZE)) begin
      w_eff = sbrs_pkg::EFFW_W'(sbrs_pkg::MIN_SIZE);
    end else if (32'(line_width_i) > sbrs_pkg::LINE_MAX) begin
      w_eff = sbrs_pkg::EFFW_W'(sbrs_pkg::LINE_MAX);
    end else begin
      w_eff = sbrs_pkg::EFFW_W'(line_width_i);
    end
    if (frame_height_i < sbrs_pkg::FH_W'(sbrs_pkg::MIN_SIZE)) begin
      h_eff = sbrs_pkg::EFFH_W'(sbrs_pkg::MIN_SIZE);
    end else if (32'(frame_height_i) > sbrs_pkg::FRAME_MAX) begin
      h_eff = sbrs_pkg::EFFH_W'(sbrs_pkg::FRAME_MAX);
    end else begin
      h_eff = sbrs_pkg::EFFH_W'(frame_height_i);
    end
  end

  assign last_col = (sbrs_pkg::EFFW_W'(col_r) + sbrs_pkg::EFFW_W'(1)) >= w_eff;
  assign last_row = (sbrs_pkg::EFFH_W'(row_r) + sbrs_pkg::EFFH_W'(1)) >= h_eff;
  // a pixel arriving after the last line restarts the frame
  assign col_use  = (!q_cmd_i.drain && draining_r) ? '0 : col_r;
  assign emit     = cmd_drain_r || (row_r != '0);
  assign can_load = !out_valid_r || out_ready;

  sbrs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (div_start),
    .num_i   (q_cmd_i.scene),
    .den_i   (q_cmd_i.backdrop),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbrs_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          if (!q_cmd_i.drain)  state_nxt = sbrs_pkg::ST_DIV;
          else if (draining_r) state_nxt = sbrs_pkg::ST_FIN;
        end
      end
      sbrs_pkg::ST_DIV: if (div_done) state_nxt = sbrs_pkg::ST_SUM;
      sbrs_pkg::ST_SUM: state_nxt = sbrs_pkg::ST_FIN;
      sbrs_pkg::ST_FIN: if (fin_go) state_nxt = sbrs_pkg::ST_IDLE;
      default: state_nxt = sbrs_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop       = 1'b0;
    rd_en     = 1'b0;
    div_start = 1'b0;
    fin_go    = 1'b0;
    unique case (state_r)
      sbrs_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          pop       = 1'b1;
          rd_en     = 1'b1;
          div_start = !q_cmd_i.drain;
        end
      end
      sbrs_pkg::ST_FIN: fin_go = !emit || can_load;
      default: ;
    endcase
  end

  assign pop_o = pop;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= sbrs_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // new pixel cell from the divider
  always_comb begin
    pix.shadow = cmd_shadow_r;
    for (int l = 0; l < sbrs_pkg::LANES; l++) begin
      pix.ratio[l] = cmd_shadow_r ? quot[l] : sbrs_pkg::INVALID_RATIO;
    end
  end

  // command latch and five-point sums
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_drain_r  <= q_cmd_i.drain;
      cmd_shadow_r <= q_cmd_i.shadow;
    end
    if (state_r == sbrs_pkg::ST_SUM) begin
      for (int l = 0; l < sbrs_pkg::LANES; l++) begin
        sum_r[l] <= sbrs_pkg::SUM_W'(rd_self_r.ratio[l]) + sbrs_pkg::SUM_W'(rd_up_r.ratio[l]) +
                    sbrs_pkg::SUM_W'(left_r.ratio[l]) + sbrs_pkg::SUM_W'(rd_right_r.ratio[l]) +
                    sbrs_pkg::SUM_W'(pix.ratio[l]);
      end
    end
  end

  // result: mean by reciprocal multiply for interior pixels
  always_comb begin
    interior = !cmd_drain_r && rd_self_r.shadow && (row_r >= sbrs_pkg::ROW_W'(2)) &&
               (col_r != '0) && !last_col && rd_up_r.shadow && left_r.shadow &&
               rd_right_r.shadow && pix.shadow;
    res = rd_self_r;
    for (int l = 0; l < sbrs_pkg::LANES; l++) begin
      prod[l] = PROD_W'(sum_r[l]) * PROD_W'(sbrs_pkg::MEAN_RECIP);
      if (!rd_self_r.shadow) res.ratio[l] = sbrs_pkg::INVALID_RATIO;
      else if (interior)     res.ratio[l] = prod[l][sbrs_pkg::MEAN_SHIFT +: sbrs_pkg::RATIO_W];
    end
  end

  // raw line store
  always_ff @(posedge clk) begin
    if (fin_go && !cmd_drain_r) begin
      raw_mem[{~bank_r, col_r}] <= pix;
    end
    if (rd_en) begin
      rd_self_r  <= raw_mem[{bank_r, col_use}];
      rd_right_r <= raw_mem[{bank_r, col_use + 1'b1}];
    end
  end

  // smoothed line store
  always_ff @(posedge clk) begin
    if (fin_go && emit) begin
      smooth_mem[col_r] <= res;
    end
    if (rd_en) begin
      rd_up_r <= smooth_mem[col_use];
    end
  end

  // position, bank and left neighbour
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      bank_r     <= 1'b0;
      draining_r <= 1'b0;
      left_r     <= '0;
    end else begin
      if (pop && !q_cmd_i.drain && draining_r) begin
        draining_r <= 1'b0;
        row_r      <= '0;
        col_r      <= '0;
      end
      if (fin_go) begin
        if (emit) left_r <= res;
        if (last_col) begin
          col_r <= '0;
          if (cmd_drain_r) begin
            draining_r <= 1'b0;
            row_r      <= '0;
          end else begin
            bank_r <= ~bank_r;
            if (last_row) draining_r <= 1'b1;
            else          row_r      <= row_r + 1'b1;
          end
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go && emit) begin
      out_data_r.is_shadow   <= rd_self_r.shadow;
      out_data_r.is_border   <= rd_self_r.shadow && !interior;
      out_data_r.ratio_blue  <= res.ratio[0];
      out_data_r.ratio_green <= res.ratio[1];
      out_data_r.ratio_red   <= res.ratio[2];
      out_data_r.frame_end   <= cmd_drain_r && last_col;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SBRS_ASSERT_NEXT(a_div_to_sum, div_done, state_r == sbrs_pkg::ST_SUM, "divider done out of step")
  `SBRS_ASSERT_NEXT(a_emit_loads, fin_go && emit, out_valid_r, "result not registered")
  `SBRS_ASSERT_NOW(a_pop_idle, pop, state_r == sbrs_pkg::ST_IDLE && q_valid_i, "bad queue pop")

endmodule

>>> src/shadow_brightness_ratio_smoother_core.sv
// Shadow brightness ratio smoother: the back end takes a pixel from the queue,
// divides it in the three-lane radix-16 divider, adds the five neighbours, then
// scales by 1/5 and writes the line stores; a drain item skips the divider and
// the sum. The divider sets the pixel rate unless the output stalls. Results
// trail the input by one line; after the last line, drain items bring out the
// held line. A two-entry queue takes input transfers while the back end is busy.
// Depends on sbrs_pkg, sbrs_front and sbrs_back.
module shadow_brightness_ratio_smoother_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sbrs_pkg::sbrs_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sbrs_pkg::sbrs_out_t            out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sbrs_pkg::PADDR_W-1:0]   paddr,
  input  logic [sbrs_pkg::PDATA_W-1:0]   pwdata,
  output logic [sbrs_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [sbrs_pkg::LW_W-1:0] line_width_r;
  logic [sbrs_pkg::FH_W-1:0] frame_height_r;
  logic                      cfg_wr;
  logic                      q_valid, pop;
  sbrs_pkg::sbrs_cmd_t       q_cmd;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= sbrs_pkg::LINE_WIDTH_RST;
      frame_height_r <= sbrs_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        sbrs_pkg::CFG_IDX_LINE_WIDTH:   line_width_r   <= pwdata[sbrs_pkg::LW_W-1:0];
        sbrs_pkg::CFG_IDX_FRAME_HEIGHT: frame_height_r <= pwdata[sbrs_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sbrs_pkg::CFG_IDX_LINE_WIDTH:   prdata = sbrs_pkg::PDATA_W'(line_width_r);
      sbrs_pkg::CFG_IDX_FRAME_HEIGHT: prdata = sbrs_pkg::PDATA_W'(frame_height_r);
      default:                        prdata = '0;
    endcase
  end

  sbrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .pop_i     (pop),
    .q_valid_o (q_valid),
    .q_cmd_o   (q_cmd)
  );

  sbrs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .line_width_i   (line_width_r),
    .frame_height_i (frame_height_r),
    .q_valid_i      (q_valid),
    .q_cmd_i        (q_cmd),
    .pop_o          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule
